// ===== rtl/gccc_pkg.sv =====
// ---------------------------------------------------------------------------
// gccc_pkg - shared types and constants for the grid cell clearance check
// Table sizing, register indexes, command and cause codes, and the types
// passed between the sequencer and the distance unit.
// ---------------------------------------------------------------------------
`default_nettype none

package gccc_pkg;

  // Obstacle table depth and the widths that follow from it
  localparam int MAX_OBSTACLES = 64;
  localparam int TAB_AW        = $clog2(MAX_OBSTACLES);
  localparam int TAB_CW        = $clog2(MAX_OBSTACLES + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_RADIUS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_COUNT = 3'd4;

  // Commands carried by an input beat
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Margins in Q12.4: 4.0 to the walls, 8.0 around each obstacle
  localparam int WALL_MARGIN = 64;
  localparam int OBST_MARGIN = 128;

  typedef enum logic [1:0] {
    CAUSE_CLEAR = 2'd0,
    CAUSE_WALL  = 2'd1,
    CAUSE_OBST  = 2'd2
  } cause_t;

  // One obstacle table entry
  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] r;
  } gccc_entry_t;

  // Status back from the distance unit
  typedef struct packed {
    logic busy;       // a compare is still in the pipe
    logic hit_valid;  // hit below is meaningful this cycle
    logic hit;        // cell center strictly inside the obstacle limit
  } gccc_dist_stat_t;

endpackage

`default_nettype wire

// ===== rtl/grid_cell_clearance_check.sv =====
// ---------------------------------------------------------------------------
// grid_cell_clearance_check - grid cell clearance against walls and obstacles
// Holds a table of circular obstacles. A write beat stores one entry; a query
// beat reports whether a grid cell center is too near a map edge or an
// obstacle.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ---------------------------------
//  in       sink       in_valid / in_stall    command cell_x cell_y slot
//                                             center_x center_y radius
//  out      source     out_valid / out_stall  blocked cause
//  cfg      sink       cfg_we                 cfg_index cfg_data
//
//  A write beat goes from S_IDLE straight to S_DONE. A query runs S_MULX and
//  S_MULY on the shared center multiplier, one wall compare, and ends when
//  the wall test blocks it; else it reads n = min(obstacle_count, 64) table
//  entries, one per cycle, through the single RAM read port and a 3-stage
//  distance pipe. in_stall is high while an item is at work.
//  The result sits in an output register; the next beat is accepted while it
//  waits on out_stall. Reset is synchronous and restores the register
//  defaults; the obstacle table is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_cell_clearance_check (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [gccc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gccc_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          command,
  input  wire logic signed [10:0]            cell_x,
  input  wire logic signed [10:0]            cell_y,
  input  wire logic [5:0]                    slot,
  input  wire logic [15:0]                   center_x,
  input  wire logic [15:0]                   center_y,
  input  wire logic [15:0]                   radius,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               blocked,
  output logic [1:0]                         cause
);

  import gccc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_WALL,
    S_SCAN,
    S_DONE
  } state_t;

  // configuration registers
  logic [11:0] cell_size;
  logic [15:0] robot_radius;
  logic [15:0] map_width;
  logic [15:0] map_height;
  logic [6:0]  obstacle_count;

  // sequencer
  state_t             state;
  logic signed [10:0] qx;
  logic signed [10:0] qy;
  logic signed [24:0] px;        // cell centers, Q.5
  logic signed [24:0] py;
  logic [TAB_CW-1:0]  iss;       // next table entry to read
  logic [TAB_CW-1:0]  scan_n;    // entries to read for this query
  logic               rv;        // RAM read data valid
  logic               hit;
  logic               res_blocked;
  cause_t             res_cause;

  logic               in_accept;
  logic               ram_we;
  logic               ram_re;
  gccc_entry_t        wentry;
  gccc_entry_t        rentry;
  gccc_dist_stat_t    dstat;

  logic signed [11:0] mul_op;
  logic signed [24:0] mul_prod;
  logic [17:0]        wm;
  logic signed [25:0] pxe;
  logic signed [25:0] pye;
  logic signed [25:0] wme;
  logic signed [25:0] wde;
  logic signed [25:0] hte;
  logic               wall_hit;
  logic [TAB_CW-1:0]  n_lim;
  logic               scan_done;

  // -------------------------------------------------------------------------
  // configuration writes
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size      <= 12'd16;
      robot_radius   <= 16'd0;
      map_width      <= 16'hFFFF;
      map_height     <= 16'hFFFF;
      obstacle_count <= 7'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_SIZE:      cell_size      <= cfg_data[11:0];
        REG_ROBOT_RADIUS:   robot_radius   <= cfg_data;
        REG_MAP_WIDTH:      map_width      <= cfg_data;
        REG_MAP_HEIGHT:     map_height     <= cfg_data;
        REG_OBSTACLE_COUNT: obstacle_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // input side and table writes
  // -------------------------------------------------------------------------
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // slots past the table depth are acknowledged but not stored
  assign ram_we = in_accept && (command == CMD_WRITE) && (32'(slot) < MAX_OBSTACLES);

  assign wentry.cx = center_x;
  assign wentry.cy = center_y;
  assign wentry.r  = radius;

  // -------------------------------------------------------------------------
  // shared center multiplier: (2*index + 1) * cell_size, x first then y
  // -------------------------------------------------------------------------
  assign mul_op   = (state == S_MULY) ? {qy, 1'b1} : {qx, 1'b1};
  assign mul_prod = 25'(mul_op) * 25'($signed({1'b0, cell_size}));

  // -------------------------------------------------------------------------
  // wall margin test, everything doubled into Q.5
  // -------------------------------------------------------------------------
  assign wm  = {17'(robot_radius) + 17'(WALL_MARGIN), 1'b0};
  assign pxe = 26'(px);
  assign pye = 26'(py);
  assign wme = $signed(26'(wm));
  assign wde = $signed(26'({map_width, 1'b0}));
  assign hte = $signed(26'({map_height, 1'b0}));

  assign wall_hit = (pxe < wme) || (pye < wme) || (pxe + wme > wde) || (pye + wme > hte);

  // counts above the table depth scan the whole table
  assign n_lim = (32'(obstacle_count) > MAX_OBSTACLES) ? TAB_CW'(MAX_OBSTACLES)
                                                       : TAB_CW'(obstacle_count);

  // -------------------------------------------------------------------------
  // obstacle scan: one read per cycle, then drain the distance pipe
  // -------------------------------------------------------------------------
  assign ram_re    = (state == S_SCAN) && (iss != scan_n);
  assign scan_done = (state == S_SCAN) && (iss == scan_n) && !rv && !dstat.busy;

  gccc_ram #(
    .WIDTH ($bits(gccc_entry_t)),
    .DEPTH (MAX_OBSTACLES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (TAB_AW'(slot)),
    .wdata (wentry),
    .re    (ram_re),
    .raddr (iss[TAB_AW-1:0]),
    .rdata (rentry)
  );

  // px and py are inside the map here, so 17 bits hold them
  gccc_dist u_dist (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (rv),
    .px           (px[16:0]),
    .py           (py[16:0]),
    .robot_radius (robot_radius),
    .entry        (rentry),
    .stat         (dstat)
  );

  // -------------------------------------------------------------------------
  // sequencer and output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rv <= ram_re;
      // S_DONE reloads the output register itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            qx <= cell_x;
            qy <= cell_y;
            if (command == CMD_QUERY) begin
              state <= S_MULX;
            end else begin
              res_blocked <= 1'b0;
              res_cause   <= CAUSE_CLEAR;
              state       <= S_DONE;
            end
          end
        end
        S_MULX: begin
          px    <= mul_prod;
          state <= S_MULY;
        end
        S_MULY: begin
          py    <= mul_prod;
          state <= S_WALL;
        end
        S_WALL: begin
          iss    <= '0;
          scan_n <= n_lim;
          hit    <= 1'b0;
          if (wall_hit) begin
            res_blocked <= 1'b1;
            res_cause   <= CAUSE_WALL;
            state       <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ram_re) begin
            iss <= iss + 1'b1;
          end
          // any hit blocks; which obstacle hit first does not matter
          if (dstat.hit_valid && dstat.hit) begin
            hit <= 1'b1;
          end
          if (scan_done) begin
            res_blocked <= hit;
            res_cause   <= hit ? CAUSE_OBST : CAUSE_CLEAR;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            blocked   <= res_blocked;
            cause     <= res_cause;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_no_rw_overlap : assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_read_in_range : assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (iss < scan_n))
    else $error("table read past the scan count");

  a_hit_in_scan : assert property (@(posedge clk) disable iff (rst)
    dstat.hit_valid |-> (state == S_SCAN))
    else $error("distance result outside a scan");

  a_cause_matches : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (blocked == (cause != CAUSE_CLEAR)))
    else $error("blocked flag disagrees with cause");

endmodule

`default_nettype wire

// ===== rtl/gccc_ram.sv =====
// ---------------------------------------------------------------------------
// gccc_ram - generic single write, single read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module gccc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gccc_dist.sv =====
// ---------------------------------------------------------------------------
// gccc_dist - pipelined squared distance compare
// Three stages: differences and limit, squares, sum and compare. Takes one
// table entry per cycle against the current cell center.
// ---------------------------------------------------------------------------
`default_nettype none

module gccc_dist (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [16:0]              px,     // cell center, Q.5, known >= 0
  input  wire logic [16:0]              py,
  input  wire logic [15:0]              robot_radius,
  input  wire gccc_pkg::gccc_entry_t    entry,
  output gccc_pkg::gccc_dist_stat_t     stat
);

  import gccc_pkg::*;

  logic               v1;
  logic               v2;
  logic               v3;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic        [18:0] md;
  logic        [34:0] dx2;
  logic        [34:0] dy2;
  logic        [37:0] md2;
  logic               hit;

  logic        [17:0] msum;
  logic signed [35:0] dxsq;
  logic signed [35:0] dysq;

  assign msum = 18'(robot_radius) + 18'(entry.r) + 18'(OBST_MARGIN);
  assign dxsq = 36'(dx) * 36'(dx);
  assign dysq = 36'(dy) * 36'(dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    // stage 1: both operands are in range for an 18-bit signed difference
    dx  <= $signed({1'b0, px}) - $signed({1'b0, entry.cx, 1'b0});
    dy  <= $signed({1'b0, py}) - $signed({1'b0, entry.cy, 1'b0});
    md  <= {msum, 1'b0};
    // stage 2
    dx2 <= dxsq[34:0];
    dy2 <= dysq[34:0];
    md2 <= 38'(md) * 38'(md);
    // stage 3
    hit <= (38'(dx2) + 38'(dy2)) < md2;
  end

  assign stat.busy      = v1 | v2 | v3;
  assign stat.hit_valid = v3;
  assign stat.hit       = hit;

endmodule

`default_nettype wire
